### design/first_fit_block_allocator_core_macros.svh
// Assertion macros used by the allocator checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define FFBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define FFBA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  // Fixed field widths
  localparam int ADDR_W  = 20;   // payload address field
  localparam int SIZE_W  = 20;   // request / entry size
  localparam int TOP_W   = 21;   // heap top and heap limit
  localparam int SUM_W   = 22;   // running payload offset and sums
  localparam int ENTRY_W = SIZE_W + 1;  // {free, size}

  localparam logic [TOP_W-1:0] HEAP_LIMIT_RESET = 21'h100000;

  // Register index as seen on paddr[2]
  localparam logic REG_HEAP_LIMIT = 1'b0;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOOP     = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_UNKNOWN  = 2'd3
  } ffba_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } ffba_state_t;

  // Shared adder request / response
  typedef struct packed {
    logic [SUM_W-1:0]  opa;
    logic [SIZE_W-1:0] opb;
    logic              add_hdr;
  } ffba_alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
  } ffba_alu_rsp_t;

endpackage

### design/ffba_alu.sv
// Shared adder: payload offset walk and heap growth sum.
module ffba_alu #(
  parameter int HEADER_BYTES = 16
) (
  input  ffba_pkg::ffba_alu_req_t req,
  output ffba_pkg::ffba_alu_rsp_t rsp
);
  import ffba_pkg::*;

  localparam logic [SUM_W-1:0] Hdr = SUM_W'(HEADER_BYTES);

  // a + b, plus one header when stepping over a block
  assign rsp.sum = req.opa + SUM_W'(req.opb) + (req.add_hdr ? Hdr : '0);

endmodule

### design/ffba_table.sv
// Block table memory: one {free, size} word per block.
module ffba_table #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(MAX_BLOCKS)-1:0]        waddr,
  input  logic [ffba_pkg::ENTRY_W-1:0]         wdata,
  input  logic [$clog2(MAX_BLOCKS)-1:0]        raddr,
  output logic [ffba_pkg::ENTRY_W-1:0]         rdata
);
  import ffba_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_BLOCKS];
  logic [ENTRY_W-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/ffba_seq.sv
// Sequencer: walks the block table one entry per cycle and builds the result.
module ffba_seq #(
  parameter int MAX_BLOCKS   = 64,
  parameter int ADDR_BITS    = 20,
  parameter int HEADER_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [ffba_pkg::SIZE_W-1:0]       in_req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]       in_release_addr,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ffba_pkg::ADDR_W-1:0]       out_payload_addr,
  output ffba_pkg::ffba_status_t            out_status,
  output logic [ffba_pkg::TOP_W-1:0]        out_top_of_heap,
  // configuration
  input  logic [ffba_pkg::TOP_W-1:0]        heap_limit,
  // table
  output logic                              mem_we,
  output logic [$clog2(MAX_BLOCKS)-1:0]     mem_waddr,
  output logic [ffba_pkg::ENTRY_W-1:0]      mem_wdata,
  output logic [$clog2(MAX_BLOCKS)-1:0]     mem_raddr,
  input  logic [ffba_pkg::ENTRY_W-1:0]      mem_rdata,
  // shared adder
  output ffba_pkg::ffba_alu_req_t           alu_req,
  input  ffba_pkg::ffba_alu_rsp_t           alu_rsp
);
  import ffba_pkg::*;

  localparam int IdxW = $clog2(MAX_BLOCKS);
  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [SUM_W-1:0] Hdr = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] AddrSpace =
    (ADDR_BITS >= SUM_W) ? {SUM_W{1'b1}} : SUM_W'(64'd1 << ADDR_BITS);
  localparam logic [ADDR_W-1:0] AddrMask =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_BLOCKS);

  ffba_state_t state_r, state_nxt;

  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [SUM_W-1:0]  pay_r, pay_nxt;      // payload address of entry idx_r
  logic              op_r, op_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] rel_r, rel_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  ffba_status_t      res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  ffba_status_t      out_status_r, out_status_nxt;
  logic [TOP_W-1:0]  out_top_r, out_top_nxt;

  logic              ent_free;
  logic [SIZE_W-1:0] ent_size;
  logic              fit, hit, last, grow_fail, out_free, accept;
  logic [SUM_W-1:0]  lim;

  // entry decode and compares
  assign ent_free  = mem_rdata[SIZE_W];
  assign ent_size  = mem_rdata[SIZE_W-1:0];
  assign fit       = ent_free && (ent_size >= req_r);
  assign hit       = (pay_r == SUM_W'(rel_r));
  assign last      = ((CntW'(idx_r) + CntW'(1)) == cnt_r);
  assign lim       = (SUM_W'(heap_limit) < AddrSpace) ? SUM_W'(heap_limit) : AddrSpace;
  assign grow_fail = (cnt_r == CntFull) || (alu_rsp.sum > lim);
  assign out_free  = !out_valid_r || out_ready;
  assign accept    = in_valid && (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ALLOC) begin
            if (in_req_size == '0)   state_nxt = S_DONE;
            else if (cnt_r == '0)    state_nxt = S_TAIL;
            else                     state_nxt = S_SCAN;
          end else begin
            if (in_release_addr == '0 || cnt_r == '0) state_nxt = S_DONE;
            else                                       state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (op_r == OP_ALLOC) begin
          if (fit)       state_nxt = S_DONE;
          else if (last) state_nxt = S_TAIL;
        end else begin
          if (hit || last) state_nxt = S_DONE;
        end
      end
      S_TAIL: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  // control outputs: handshake, table port, adder operands
  always_comb begin
    in_ready        = 1'b0;
    mem_raddr       = '0;
    mem_we          = 1'b0;
    mem_waddr       = idx_r;
    mem_wdata       = {1'b0, ent_size};
    alu_req.opa     = pay_r;
    alu_req.opb     = ent_size;
    alu_req.add_hdr = 1'b1;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: begin
        // prefetch the following entry
        mem_raddr = IdxW'(CntW'(idx_r) + CntW'(1));
        if (op_r == OP_ALLOC && fit) begin
          mem_we = 1'b1;
        end else if (op_r == OP_RELEASE && hit && !last) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, ent_size};
        end
      end
      S_TAIL: begin
        alu_req.opb     = req_r;
        alu_req.add_hdr = 1'b0;
        mem_we          = !grow_fail;
        mem_waddr       = cnt_r[IdxW-1:0];
        mem_wdata       = {1'b0, req_r};
      end
      S_DONE: ;
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    top_nxt        = top_r;
    pay_nxt        = pay_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    rel_nxt        = rel_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          req_nxt        = in_req_size;
          rel_nxt        = in_release_addr;
          idx_nxt        = '0;
          pay_nxt        = Hdr;
          res_addr_nxt   = '0;
          res_status_nxt = ST_NOOP;
          if (in_op == OP_RELEASE && in_release_addr != '0 && cnt_r == '0) begin
            res_status_nxt = ST_UNKNOWN;
          end
        end
      end
      S_SCAN: begin
        if (op_r == OP_ALLOC && fit) begin
          res_addr_nxt   = pay_r[ADDR_W-1:0] & AddrMask;
          res_status_nxt = ST_OK;
        end else if (op_r == OP_RELEASE && hit) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          if (last) begin
            // last block goes away: heap shrinks to its header
            cnt_nxt = cnt_r - CntW'(1);
            top_nxt = TOP_W'(pay_r - Hdr);
          end
        end else begin
          pay_nxt = alu_rsp.sum;
          idx_nxt = IdxW'(CntW'(idx_r) + CntW'(1));
          if (last && op_r == OP_RELEASE) begin
            res_addr_nxt   = '0;
            res_status_nxt = ST_UNKNOWN;
          end
        end
      end
      S_TAIL: begin
        if (grow_fail) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_NO_SPACE;
        end else begin
          res_addr_nxt   = pay_r[ADDR_W-1:0] & AddrMask;
          res_status_nxt = ST_OK;
          cnt_nxt        = cnt_r + CntW'(1);
          top_nxt        = TOP_W'(alu_rsp.sum);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_top_nxt    = top_r;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pay_r        <= pay_nxt;
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    rel_r        <= rel_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_addr = out_addr_r;
  assign out_status       = out_status_r;
  assign out_top_of_heap  = out_top_r;

endmodule

### design/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator: streams, register port, table walk.
//
// Input stream (in_*): one item per allocate or release request; in_tuser is
// the operation (0 allocate, 1 release). Output stream (out_*): one result item
// per request with payload address, status and heap top after the request.
// Register port (cfg_*): heap_limit at byte address 0, written with the usual
// setup and access cycles; pready is always high.
// A first-fit hit or a release walks the table entries up to the match; an
// allocate that appends walks the whole table (the current block count) and
// then grows the heap in a tail step. Null requests and a release on an empty
// table go straight to the result; an allocate on an empty table goes straight
// to the tail step. The block table has a single read port and is walked one
// entry per cycle while the shared adder advances the payload offset.
// One item is in work at a time; in_tready is low meanwhile.
// Reset clears the block count, the heap top and the output valid, and sets
// heap_limit to 1 MiB; table entries are written before they are ever read.
// A stalled receiver holds the result in the output register; the next item is
// still accepted and its result waits in the sequencer until the slot frees.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = 64,
  parameter int ADDR_BITS    = 20,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [19:0] req_size, [39:20] release_addr
  input  logic        in_tuser,    // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [19:0] payload_addr, [21:20] status,
                                   // [42:22] top_of_heap, [47:43] zero
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffba_pkg::*;

  localparam int IdxW = $clog2(MAX_BLOCKS);

  logic [TOP_W-1:0]  heap_limit_r, heap_limit_nxt;
  logic              cfg_wr;

  logic [ADDR_W-1:0] res_addr;
  ffba_status_t      res_status;
  logic [TOP_W-1:0]  res_top;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  ffba_alu_req_t      alu_req;
  ffba_alu_rsp_t      alu_rsp;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    heap_limit_nxt = heap_limit_r;
    if (cfg_wr && cfg_paddr[2] == REG_HEAP_LIMIT) begin
      heap_limit_nxt = cfg_pwdata[TOP_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_HEAP_LIMIT: cfg_prdata = {{(32 - TOP_W){1'b0}}, heap_limit_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= HEAP_LIMIT_RESET;
    end else begin
      heap_limit_r <= heap_limit_nxt;
    end
  end

  ffba_seq #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .in_op            (in_tuser),
    .in_req_size      (in_tdata[19:0]),
    .in_release_addr  (in_tdata[39:20]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_payload_addr (res_addr),
    .out_status       (res_status),
    .out_top_of_heap  (res_top),
    .heap_limit       (heap_limit_r),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp)
  );

  ffba_table #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffba_alu #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // result packing, lowest field first
  assign out_tdata = {5'b0, res_top, res_status, res_addr};

endmodule

### design/ffba_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "first_fit_block_allocator_core_macros.svh"

module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);
  import ffba_pkg::*;

  // one item in work at a time
  `FFBA_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input ready right after an accept")

  // a stalled result holds
  `FFBA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // only a successful allocate carries an address
  `FFBA_ASSERT(a_addr_zero, clk, rst_n, out_tvalid && out_tdata[21:20] != ST_OK |-> out_tdata[19:0] == '0, "address on a non-ok result")

  // reset empties the output register
  `FFBA_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
